[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled while rst_n low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define CHK_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define CHK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lds_pkg.sv]
// ----------------------------------------------------------------------------
// lds_pkg
// types and constants of the leakage detector self-test sequencer
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_PRESENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd6;

  // reset values of the delay registers
  localparam logic [DELAY_W-1:0] RST_CAL_HIGH     = 16'd100;
  localparam logic [DELAY_W-1:0] RST_CAL_LOW      = 16'd75;
  localparam logic [DELAY_W-1:0] RST_TEST_DELAY   = 16'd500;
  localparam logic [DELAY_W-1:0] RST_TRIP_TIMEOUT = 16'd400;
  localparam logic [DELAY_W-1:0] RST_SETTLE       = 16'd200;

  typedef enum logic [STEP_W-1:0] {
    STEP_PREPARE   = 3'd0,
    STEP_CAL_HIGH  = 3'd1,
    STEP_CAL_LOW   = 3'd2,
    STEP_TEST_WAIT = 3'd3,
    STEP_WAIT_TRIP = 3'd4,
    STEP_SETTLE    = 3'd5,
    STEP_DETECT    = 3'd6,
    STEP_ERROR     = 3'd7
  } step_t;

  typedef struct packed {
    logic               detect_mode;
    logic               trip_line_present;
    logic [DELAY_W-1:0] cal_high_ms;
    logic [DELAY_W-1:0] cal_low_ms;
    logic [DELAY_W-1:0] test_delay_ms;
    logic [DELAY_W-1:0] trip_timeout_ms;
    logic [DELAY_W-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic  cal_line;
    logic  test_line;
    logic  leak_protect_fault;
    logic  cal_error_fault;
    step_t seq_step;
  } result_t;

endpackage

[design/lds_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lds_cfg_regs
// configuration register file, written one word at a time
// ----------------------------------------------------------------------------
module lds_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lds_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lds_pkg::DELAY_W-1:0]    wr_data,
  output lds_pkg::cfg_t                  cfg
);
  import lds_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DETECT_MODE:  cfg_nxt.detect_mode       = wr_data[0];
        REG_TRIP_PRESENT: cfg_nxt.trip_line_present = wr_data[0];
        REG_CAL_HIGH:     cfg_nxt.cal_high_ms       = wr_data;
        REG_CAL_LOW:      cfg_nxt.cal_low_ms        = wr_data;
        REG_TEST_DELAY:   cfg_nxt.test_delay_ms     = wr_data;
        REG_TRIP_TIMEOUT: cfg_nxt.trip_timeout_ms   = wr_data;
        REG_SETTLE:       cfg_nxt.settle_ms         = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode       <= 1'b0;
      cfg_r.trip_line_present <= 1'b1;
      cfg_r.cal_high_ms       <= RST_CAL_HIGH;
      cfg_r.cal_low_ms        <= RST_CAL_LOW;
      cfg_r.test_delay_ms     <= RST_TEST_DELAY;
      cfg_r.trip_timeout_ms   <= RST_TRIP_TIMEOUT;
      cfg_r.settle_ms         <= RST_SETTLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/lds_seq_core.sv]
// ----------------------------------------------------------------------------
// lds_seq_core
// self-test step register, step stamp and line levels, updated once per poll
// ----------------------------------------------------------------------------
module lds_seq_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         poll,
  input  logic [lds_pkg::TIME_W-1:0]   now_ms,
  input  logic                         trip_level,
  input  lds_pkg::cfg_t                cfg,
  output lds_pkg::result_t             res
);
  import lds_pkg::*;

  step_t               step_r,  step_nxt;
  logic [TIME_W-1:0]   stamp_r, stamp_nxt;
  logic                cal_r,   cal_nxt;
  logic                test_r,  test_nxt;

  logic [TIME_W-1:0]   elapsed;
  logic [DELAY_W-1:0]  limit;
  logic                passed;
  logic                leak;
  logic                calerr;

  // at most one delay per step, so a single subtract and compare serves all of them
  always_comb begin
    case (step_r)
      STEP_CAL_HIGH:  limit = cfg.cal_high_ms;
      STEP_CAL_LOW:   limit = cfg.cal_low_ms;
      STEP_TEST_WAIT: limit = cfg.test_delay_ms;
      STEP_WAIT_TRIP: limit = cfg.trip_timeout_ms;
      STEP_SETTLE:    limit = cfg.settle_ms;
      default:        limit = '0;
    endcase
  end

  assign elapsed = now_ms - stamp_r;
  assign passed  = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, limit};

  always_comb begin
    step_nxt  = step_r;
    stamp_nxt = stamp_r;
    cal_nxt   = cal_r;
    test_nxt  = test_r;
    leak      = 1'b0;
    calerr    = 1'b0;
    if (!cfg.detect_mode) begin
      // plain mode: sequence frozen, fault follows the sense line
      leak = cfg.trip_line_present & trip_level;
    end else begin
      case (step_r)
        STEP_PREPARE: begin
          cal_nxt   = 1'b1;
          test_nxt  = 1'b0;
          stamp_nxt = now_ms;
          step_nxt  = STEP_CAL_HIGH;
        end
        STEP_CAL_HIGH: begin
          if (passed) begin
            cal_nxt   = 1'b0;
            stamp_nxt = now_ms;
            step_nxt  = STEP_CAL_LOW;
          end
        end
        STEP_CAL_LOW: begin
          if (passed) begin
            cal_nxt   = 1'b1;
            stamp_nxt = now_ms;
            step_nxt  = STEP_TEST_WAIT;
          end
        end
        STEP_TEST_WAIT: begin
          if (passed) begin
            test_nxt  = 1'b1;
            stamp_nxt = now_ms;
            step_nxt  = STEP_WAIT_TRIP;
          end
        end
        STEP_WAIT_TRIP: begin
          // timeout wins over a trip seen on the same poll
          if (passed) begin
            test_nxt = 1'b0;
            step_nxt = STEP_ERROR;
          end else if (cfg.trip_line_present && trip_level) begin
            stamp_nxt = now_ms;
            step_nxt  = STEP_SETTLE;
          end
        end
        STEP_SETTLE: begin
          if (passed) begin
            step_nxt = STEP_DETECT;
          end
        end
        STEP_DETECT: begin
          leak = trip_level;
        end
        STEP_ERROR: begin
          calerr = 1'b1;
        end
        default: begin
          calerr = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_PREPARE;
      stamp_r <= '0;
      cal_r   <= 1'b0;
      test_r  <= 1'b0;
    end else if (poll) begin
      step_r  <= step_nxt;
      stamp_r <= stamp_nxt;
      cal_r   <= cal_nxt;
      test_r  <= test_nxt;
    end
  end

  assign res.cal_line           = cal_nxt;
  assign res.test_line          = test_nxt;
  assign res.leak_protect_fault = leak;
  assign res.cal_error_fault    = calerr;
  assign res.seq_step           = step_nxt;

endmodule

[design/lds_out_stage.sv]
// ----------------------------------------------------------------------------
// lds_out_stage
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
module lds_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lds_pkg::result_t    res_in,
  output logic                out_valid,
  input  logic                out_ready,
  output lds_pkg::result_t    res_out
);
  import lds_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  // a new word may enter when the register is empty or the held one leaves in the same cycle
  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

[design/leakage_detector_selftest_sequencer_top.sv]
// the result of an accepted poll is registered in the output stage
// throughput: one poll per cycle while in_ready is high; the step update is a single 32-bit subtract and
//   compare ahead of the result register
// a stalled result holds the input back only when the result register is full
// reset (rst_n low, synchronous) returns the sequence to prepare, clears both lines
//   and the stamp, and reloads the registers with their default values
// ----------------------------------------------------------------------------
// leakage_detector_selftest_sequencer_top
// leakage detector poll handler with type-B self-test sequence
// ----------------------------------------------------------------------------
module leakage_detector_selftest_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lds_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                           in_trip_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_cal_line,
  output logic                           out_test_line,
  output logic                           out_leak_protect_fault,
  output logic                           out_cal_error_fault,
  output logic [lds_pkg::STEP_W-1:0]     out_seq_step,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lds_pkg::DELAY_W-1:0]    cfg_wdata
);
  import lds_pkg::*;

  cfg_t    cfg;
  result_t res_next;
  result_t res_held;
  logic    poll;

  assign cfg_ready = 1'b1;
  assign poll      = in_valid && in_ready;

  lds_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  lds_seq_core u_seq_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll       (poll),
    .now_ms     (in_now_ms),
    .trip_level (in_trip_level),
    .cfg        (cfg),
    .res        (res_next)
  );

  lds_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_held)
  );

  assign out_cal_line           = res_held.cal_line;
  assign out_test_line          = res_held.test_line;
  assign out_leak_protect_fault = res_held.leak_protect_fault;
  assign out_cal_error_fault    = res_held.cal_error_fault;
  assign out_seq_step           = res_held.seq_step;

endmodule

[design/lds_checker.sv]
// ----------------------------------------------------------------------------
// lds_checker
// port-level checks of the self-test sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lds_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_test_line,
  input logic                         out_cal_error_fault,
  input logic [lds_pkg::STEP_W-1:0]   out_seq_step
);
  import lds_pkg::*;

  // an empty result register never blocks a poll
  `CHK_ASSERT(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // every accepted poll yields a word on the next cycle
  `CHK_ASSERT_NEXT(a_poll_gives_word, in_valid && in_ready, out_valid, "accepted poll lost")

  // a held word keeps its step while the consumer stalls
  `CHK_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_seq_step), "stalled word changed")

  // calibration error only ever reported from the error step
  `CHK_ASSERT(a_calerr_step, out_valid && out_cal_error_fault, out_seq_step == STEP_ERROR, "cal error outside error step")

  // the test line is dropped once the self-test has failed
  `CHK_ASSERT(a_error_test_low, out_valid && out_seq_step == STEP_ERROR, !out_test_line, "test line high in error step")

endmodule

bind leakage_detector_selftest_sequencer_top lds_checker u_lds_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_test_line       (out_test_line),
  .out_cal_error_fault (out_cal_error_fault),
  .out_seq_step        (out_seq_step)
);

[tb/sv/leakage_detector_selftest_sequencer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// leakage_detector_selftest_sequencer_top_tb
// drives polls through the plain trip path and the type-B self-test sequence,
// with random gaps on both sides and random register settings between chunks;
// every result word is checked against an in-bench prediction of the sequencer
// ----------------------------------------------------------------------------
module leakage_detector_selftest_sequencer_top_tb;
  import lds_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_POLLS = 1300;
  localparam int LONG_HOLD = 250;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              trip;
  } poll_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 in_trip_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_cal_line;
  logic                 out_test_line;
  logic                 out_leak_protect_fault;
  logic                 out_cal_error_fault;
  logic [STEP_W-1:0]    out_seq_step;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]   cfg_wdata = '0;

  // pending polls and the results they must produce
  poll_t   poll_q[$];
  result_t expected_results[$];

  // shadow registers and sequencer state
  cfg_t              model_cfg;
  step_t             tracked_step;
  logic [TIME_W-1:0] tracked_stamp;
  logic              cal_lvl;
  logic              test_lvl;

  int      src_gap_max = 0;
  int      src_gap_left = 0;
  int      sink_gap_max = 0;
  int      sink_stall_left = 0;
  int      long_holds = 0;
  int      results_seen = 0;
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  poll_t   issued_poll;
  result_t want;

  leakage_detector_selftest_sequencer_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_now_ms              (in_now_ms),
    .in_trip_level          (in_trip_level),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_cal_line           (out_cal_line),
    .out_test_line          (out_test_line),
    .out_leak_protect_fault (out_leak_protect_fault),
    .out_cal_error_fault    (out_cal_error_fault),
    .out_seq_step           (out_seq_step),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic bit elapsed_reached(input logic [TIME_W-1:0] now,
                                         input logic [DELAY_W-1:0] limit_ms);
    logic [TIME_W-1:0] elapsed;
    elapsed = now - tracked_stamp;
    return elapsed >= {16'h0, limit_ms};
  endfunction

  // advances the sequencer by one poll and returns its result word
  function automatic result_t sequencer_poll(input logic [TIME_W-1:0] now,
                                             input logic trip);
    result_t r;
    logic    leak;
    logic    calerr;
    leak = 1'b0;
    calerr = 1'b0;
    if (!model_cfg.detect_mode) begin
      leak = model_cfg.trip_line_present & trip;
    end else begin
      case (tracked_step)
        STEP_PREPARE: begin
          cal_lvl = 1'b1;
          test_lvl = 1'b0;
          tracked_stamp = now;
          tracked_step = STEP_CAL_HIGH;
        end
        STEP_CAL_HIGH: begin
          if (elapsed_reached(now, model_cfg.cal_high_ms)) begin
            cal_lvl = 1'b0;
            tracked_stamp = now;
            tracked_step = STEP_CAL_LOW;
          end
        end
        STEP_CAL_LOW: begin
          if (elapsed_reached(now, model_cfg.cal_low_ms)) begin
            cal_lvl = 1'b1;
            tracked_stamp = now;
            tracked_step = STEP_TEST_WAIT;
          end
        end
        STEP_TEST_WAIT: begin
          if (elapsed_reached(now, model_cfg.test_delay_ms)) begin
            test_lvl = 1'b1;
            tracked_stamp = now;
            tracked_step = STEP_WAIT_TRIP;
          end
        end
        STEP_WAIT_TRIP: begin
          // timeout wins over a trip on the same poll
          if (elapsed_reached(now, model_cfg.trip_timeout_ms)) begin
            test_lvl = 1'b0;
            tracked_step = STEP_ERROR;
          end else if (model_cfg.trip_line_present && trip) begin
            tracked_stamp = now;
            tracked_step = STEP_SETTLE;
          end
        end
        STEP_SETTLE: begin
          if (elapsed_reached(now, model_cfg.settle_ms)) tracked_step = STEP_DETECT;
        end
        STEP_DETECT: begin
          leak = trip;
        end
        default: begin
          calerr = 1'b1;
        end
      endcase
    end
    r.cal_line = cal_lvl;
    r.test_line = test_lvl;
    r.leak_protect_fault = leak;
    r.cal_error_fault = calerr;
    r.seq_step = tracked_step;
    return r;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return DELAY_W'($urandom_range(1, 200));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DETECT_MODE:  model_cfg.detect_mode = val[0];
      REG_TRIP_PRESENT: model_cfg.trip_line_present = val[0];
      REG_CAL_HIGH:     model_cfg.cal_high_ms = val;
      REG_CAL_LOW:      model_cfg.cal_low_ms = val;
      REG_TEST_DELAY:   model_cfg.test_delay_ms = val;
      REG_TRIP_TIMEOUT: model_cfg.trip_timeout_ms = val;
      REG_SETTLE:       model_cfg.settle_ms = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic queue_poll(input logic [TIME_W-1:0] now, input logic trip);
    poll_t p;
    p.now_ms = now;
    p.trip = trip;
    poll_q.push_back(p);
  endtask

  // wait until every poll is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (poll_q.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // driver: one poll word per handshake, random gap before each word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_now_ms <= '0;
      in_trip_level <= 1'b0;
      src_gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(sequencer_poll(in_now_ms, in_trip_level));
      end
      if (!in_valid || in_ready) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          in_valid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          issued_poll = poll_q.pop_front();
          in_valid <= 1'b1;
          in_now_ms <= issued_poll.now_ms;
          in_trip_level <= issued_poll.trip;
          src_gap_left = $urandom_range(0, src_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word, stalls at random, and at most twice holds off long
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with nothing expected, step=%0d", $time, out_seq_step);
        end else begin
          want = expected_results.pop_front();
          if (out_cal_line !== want.cal_line || out_test_line !== want.test_line ||
              out_leak_protect_fault !== want.leak_protect_fault ||
              out_cal_error_fault !== want.cal_error_fault ||
              out_seq_step !== want.seq_step) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch expected cal=%0b test=%0b leak=%0b calerr=%0b step=%0d",
                       $time, want.cal_line, want.test_line, want.leak_protect_fault,
                       want.cal_error_fault, want.seq_step);
              $display("  got cal=%0b test=%0b leak=%0b calerr=%0b step=%0d",
                       out_cal_line, out_test_line, out_leak_protect_fault,
                       out_cal_error_fault, out_seq_step);
            end
          end
        end
        sink_stall_left = $urandom_range(0, sink_gap_max);
        // long hold only while more words are queued, so the input backs up
        if (long_holds < 2 && results_seen >= 300 + 600 * long_holds &&
            poll_q.size() > 4) begin
          sink_stall_left = LONG_HOLD;
          long_holds++;
        end
      end
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    cfg_t              next_cfg;
    logic [TIME_W-1:0] clock_ms;
    logic [31:0]       filler;
    bit                aim_error;
    bit                noise_ok;
    int                chunk_len;
    int                span;
    int                random_polls;

    model_cfg.detect_mode = 1'b0;
    model_cfg.trip_line_present = 1'b1;
    model_cfg.cal_high_ms = RST_CAL_HIGH;
    model_cfg.cal_low_ms = RST_CAL_LOW;
    model_cfg.test_delay_ms = RST_TEST_DELAY;
    model_cfg.trip_timeout_ms = RST_TRIP_TIMEOUT;
    model_cfg.settle_ms = RST_SETTLE;
    tracked_step = STEP_PREPARE;
    tracked_stamp = '0;
    cal_lvl = 1'b0;
    test_lvl = 1'b0;
    // one reset per run, so the sequence ends either in detect or in error
    aim_error = ($urandom_range(0, 3) == 0);
    clock_ms = 32'hFFFF_FE00;
    random_polls = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plain mode at the time extremes
    queue_poll(32'h0000_0000, 1'b0);
    queue_poll(32'hFFFF_FFFF, 1'b1);
    queue_poll(32'hAAAA_AAAA, 1'b1);
    queue_poll(32'h5555_5555, 1'b0);
    queue_poll(32'hFFFF_FFFF, 1'b0);
    drain();
    // upper bits of the one-bit registers are dropped, spare index ignored
    write_reg(REG_TRIP_PRESENT, 16'hFFFE);
    write_reg(REG_DETECT_MODE, 16'hFFFE);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    queue_poll(32'd12345, 1'b1);
    queue_poll(32'd0, 1'b1);
    queue_poll(32'd7, 1'b0);

    while (random_polls < RANDOM_POLLS) begin
      drain();
      next_cfg.detect_mode = ($urandom_range(0, 3) != 0);
      next_cfg.trip_line_present = ($urandom_range(0, 3) != 0);
      next_cfg.cal_high_ms = pick_delay();
      next_cfg.cal_low_ms = pick_delay();
      next_cfg.test_delay_ms = pick_delay();
      next_cfg.trip_timeout_ms = pick_delay();
      next_cfg.settle_ms = pick_delay();
      if (aim_error) begin
        // no trip is ever taken, so the wait ends in a timeout
        if (next_cfg.detect_mode) next_cfg.trip_line_present = 1'b0;
      end else begin
        if (next_cfg.trip_timeout_ms < 16'd100) next_cfg.trip_timeout_ms = 16'd100;
        if (next_cfg.detect_mode && tracked_step < STEP_SETTLE)
          next_cfg.trip_line_present = 1'b1;
      end
      filler = $urandom;
      write_reg(REG_DETECT_MODE, {filler[15:1], next_cfg.detect_mode});
      filler = $urandom;
      write_reg(REG_TRIP_PRESENT, {filler[15:1], next_cfg.trip_line_present});
      write_reg(REG_CAL_HIGH, next_cfg.cal_high_ms);
      write_reg(REG_CAL_LOW, next_cfg.cal_low_ms);
      write_reg(REG_TEST_DELAY, next_cfg.test_delay_ms);
      write_reg(REG_TRIP_TIMEOUT, next_cfg.trip_timeout_ms);
      write_reg(REG_SETTLE, next_cfg.settle_ms);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_IDX_SPARE, 16'($urandom));

      case ($urandom_range(0, 2))
        0: src_gap_max = 0;
        1: src_gap_max = 4;
        default: src_gap_max = 16;
      endcase
      case ($urandom_range(0, 2))
        0: sink_gap_max = 0;
        1: sink_gap_max = 4;
        default: sink_gap_max = 16;
      endcase

      // stray time values only where they cannot force an unplanned timeout
      noise_ok = aim_error || !next_cfg.detect_mode ||
                 tracked_step == STEP_DETECT || tracked_step == STEP_ERROR;
      chunk_len = $urandom_range(20, 60);
      span = $urandom_range(1, 6);
      for (int k = 0; k < chunk_len; k++) begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, span));
        if (noise_ok && $urandom_range(0, 39) == 0)
          queue_poll($urandom, 1'($urandom_range(0, 1)));
        else
          queue_poll(clock_ms, ($urandom_range(0, 2) == 0));
      end
      random_polls += chunk_len;
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
